>>> hw/rtl/poma_pkg.sv
// Shared types and constants for the priority override mode arbiter.
// Holds the opcode and mode codes and the packed layout of a table entry.
// No dependencies.
`default_nettype none
package poma_pkg;

  localparam logic [2:0] OP_SET_BASE = 3'd0;
  localparam logic [2:0] OP_ENABLE   = 3'd1;
  localparam logic [2:0] OP_DISABLE  = 3'd2;
  localparam logic [2:0] OP_TIMED    = 3'd3;
  localparam logic [2:0] OP_TICK     = 3'd4;
  localparam logic [2:0] OP_ALLIANCE = 3'd5;
  localparam logic [2:0] OP_REAPPLY  = 3'd6;
  localparam logic [2:0] OP_NONE     = 3'd7;

  localparam logic [3:0] MODE_OFF     = 4'd0;
  localparam logic [3:0] MODE_RED     = 4'd2;
  localparam logic [3:0] MODE_BLUE    = 4'd3;
  localparam logic [3:0] MODE_SCORING = 4'd5;
  localparam logic [3:0] MODE_ENDGAME = 4'd7;
  localparam logic [3:0] MODE_MAX     = 4'd8;

  typedef struct packed {
    logic [3:0]  mode;
    logic [2:0]  prio;
    logic        pers;
    logic [31:0] end_ms;
  } entry_t;

endpackage
`default_nettype wire

>>> hw/rtl/priority_override_mode_arbiter_unit.sv
// Priority override mode arbiter, top level.
// The override table is a one-port-write, one-port-read synchronous memory
// scanned by a small sequencer. Depends on poma_pkg.
`default_nettype none
// An item that touches only the mode registers (set base, alliance, force
// reapply, ignored codes) goes straight to the finish state. Table commands
// scan the table once through the memory read port, one entry a cycle; a
// timed scoring request scans twice (endgame check, then update), unless
// the check finds a persistent endgame entry and refuses the request.
// The next item is taken once the current one has handed its result to the
// output register; that register holds a beat while the output stalls.
module priority_override_mode_arbiter_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [2:0]  opcode,
  input  wire  [3:0]  mode_code,
  input  wire  [2:0]  priority_level,
  input  wire  [31:0] duration_ms,
  input  wire  [31:0] now_ms,
  input  wire         alliance_red,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [3:0]  applied_mode,
  output logic        apply_now,
  output logic        refused
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;
  typedef enum logic {P_CHECK, P_MAIN} pass_t;

  state_t state;
  pass_t  pass;

  logic [3:0]    base_mode, last_mode;
  logic          red_side;
  logic [CW-1:0] count, rd, wr;
  logic          rvalid, found, blocked, apply, refuse;
  logic [3:0]    best;
  logic [2:0]    bprio;

  logic [2:0]    op;
  logic [3:0]    mode;
  logic [2:0]    prio;
  logic [31:0]   end_ms, now;

  poma_pkg::entry_t mem [TABLE_DEPTH];
  poma_pkg::entry_t rdata;

  logic             accept, done, full, push;
  logic             keep, hit;
  poma_pkg::entry_t ent;
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  poma_pkg::entry_t mem_wdata;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign done     = (state == S_SCAN) && (rd == count) && !rvalid;
  assign full     = (count == FULL);
  assign push     = done && (pass == P_MAIN) && !found && !full &&
                    ((op == poma_pkg::OP_ENABLE) || (op == poma_pkg::OP_TIMED));

  // Modify one entry coming out of the memory
  always_comb begin
    ent  = rdata;
    keep = 1'b1;
    hit  = 1'b0;
    case (op)
      poma_pkg::OP_ENABLE: begin
        if (!found && rdata.pers && rdata.mode == mode) begin
          ent.prio = prio;
          hit      = 1'b1;
        end
      end
      poma_pkg::OP_DISABLE: begin
        keep = !(rdata.pers && rdata.mode == mode);
      end
      poma_pkg::OP_TIMED: begin
        if (!found && !rdata.pers && rdata.mode == mode) begin
          if (end_ms > rdata.end_ms) ent.end_ms = end_ms;
          if (prio > rdata.prio) ent.prio = prio;
          hit = 1'b1;
        end
      end
      poma_pkg::OP_TICK: begin
        keep = rdata.pers || (now < rdata.end_ms);
      end
      default: begin
        keep = 1'b1;
      end
    endcase
  end

  // Select the write beat: compacted write-back or append at the end
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr[IW-1:0];
    mem_wdata = ent;
    if (state == S_SCAN && rvalid && pass == P_MAIN && keep) begin
      mem_we = 1'b1;
    end else if (push) begin
      mem_we    = 1'b1;
      mem_waddr = count[IW-1:0];
      mem_wdata = '{mode: mode, prio: prio,
                    pers: (op == poma_pkg::OP_ENABLE),
                    end_ms: (op == poma_pkg::OP_ENABLE) ? 32'd0 : end_ms};
    end
  end

  // Table memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[rd[IW-1:0]];
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pass      <= P_MAIN;
      base_mode <= poma_pkg::MODE_OFF;
      last_mode <= poma_pkg::MODE_OFF;
      red_side  <= 1'b1;
      count     <= '0;
      rd        <= '0;
      wr        <= '0;
      rvalid    <= 1'b0;
      found     <= 1'b0;
      blocked   <= 1'b0;
      apply     <= 1'b0;
      refuse    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // drop a delivered beat unless a new one replaces it
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op      <= (opcode <= poma_pkg::OP_TIMED && mode_code > poma_pkg::MODE_MAX)
                       ? poma_pkg::OP_NONE : opcode;
            mode    <= mode_code;
            prio    <= priority_level;
            end_ms  <= now_ms + duration_ms;
            now     <= now_ms;
            rd      <= '0;
            wr      <= '0;
            rvalid  <= 1'b0;
            found   <= 1'b0;
            blocked <= 1'b0;
            apply   <= 1'b0;
            refuse  <= 1'b0;
            best    <= base_mode;
            bprio   <= '0;
            pass    <= (opcode == poma_pkg::OP_TIMED && mode_code == poma_pkg::MODE_SCORING)
                       ? P_CHECK : P_MAIN;
            state   <= S_FIN;
            if (!(mode_code > poma_pkg::MODE_MAX)) begin
              case (opcode)
                poma_pkg::OP_SET_BASE: base_mode <= mode_code;
                poma_pkg::OP_ENABLE, poma_pkg::OP_DISABLE, poma_pkg::OP_TIMED:
                  state <= S_SCAN;
                default: ;
              endcase
            end
            case (opcode)
              poma_pkg::OP_TICK: state <= S_SCAN;
              poma_pkg::OP_ALLIANCE: begin
                red_side <= alliance_red;
                if (base_mode == poma_pkg::MODE_RED || base_mode == poma_pkg::MODE_BLUE)
                  base_mode <= alliance_red ? poma_pkg::MODE_RED : poma_pkg::MODE_BLUE;
                last_mode <= poma_pkg::MODE_OFF;
              end
              poma_pkg::OP_REAPPLY: last_mode <= poma_pkg::MODE_OFF;
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          // issue reads in order
          if (rd != count) begin
            rd     <= rd + 1'b1;
            rvalid <= 1'b1;
          end else begin
            rvalid <= 1'b0;
          end
          // fold in the entry that came back
          if (rvalid) begin
            if (pass == P_CHECK) begin
              if (rdata.pers && rdata.mode == poma_pkg::MODE_ENDGAME) blocked <= 1'b1;
            end else begin
              if (hit) found <= 1'b1;
              if (keep) begin
                wr <= wr + 1'b1;
                if (op == poma_pkg::OP_TICK && rdata.prio > bprio) begin
                  bprio <= rdata.prio;
                  best  <= rdata.mode;
                end
              end
            end
          end
          if (done) begin
            if (pass == P_CHECK) begin
              if (blocked) begin
                refuse <= 1'b1;
                state  <= S_FIN;
              end else begin
                pass <= P_MAIN;
                rd   <= '0;
                wr   <= '0;
              end
            end else begin
              state <= S_FIN;
              if (op == poma_pkg::OP_ENABLE || op == poma_pkg::OP_TIMED) begin
                if (!found) begin
                  if (full) refuse <= 1'b1;
                  else count <= count + 1'b1;
                end
              end else begin
                count <= wr;
              end
              if (op == poma_pkg::OP_TICK && best != last_mode) begin
                last_mode <= best;
                apply     <= 1'b1;
              end
            end
          end
        end
        S_FIN: begin
          // hand the result to the output register once it is free
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            applied_mode <= last_mode;
            apply_now    <= apply;
            refused      <= refuse;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
